### hdl/assert_macros.svh
// Assertion helpers. Each use expects signals named clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must never be true at a clock edge outside reset.
`define EGSA_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

// Whenever ante holds, cons must hold in the same cycle.
`define EGSA_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### hdl/egsa_pkg.sv
`timescale 1ns / 1ps
package egsa_pkg;

    localparam int VOCAB       = 1024;
    localparam int ROW_WORDS   = 16;
    localparam int ID_W        = $clog2(VOCAB);
    localparam int COL_W       = 4;
    localparam int ADDR_W      = ID_W + COL_W;
    localparam int TABLE_WORDS = VOCAB << COL_W;
    localparam int DATA_W      = 32;
    localparam int ACT_W       = 3;
    localparam int TOKEN_W     = 16;
    localparam int VOCAB_CFG_W = 11;
    localparam int DIM_CFG_W   = 5;
    localparam int CFG_DATA_W  = 11;
    localparam int CFG_IDX_W   = 1;
    localparam int VOCAB_CMP_W = 17;
    localparam int CMDQ_DEPTH  = 4;
    localparam int OUTQ_DEPTH  = 4;

    localparam logic [VOCAB_CFG_W-1:0] VOCAB_RESET = 11'd1024;
    localparam logic [DIM_CFG_W-1:0]   DIM_RESET   = 5'd16;

    localparam logic [ACT_W-1:0] ACT_LOAD      = 3'd0;
    localparam logic [ACT_W-1:0] ACT_LOOKUP    = 3'd1;
    localparam logic [ACT_W-1:0] ACT_ACCUM     = 3'd2;
    localparam logic [ACT_W-1:0] ACT_READ_GRAD = 3'd3;
    localparam logic [ACT_W-1:0] ACT_CLEAR     = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_VOCAB = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DIM   = 1'b1;

    typedef enum logic [2:0] {
        CMD_ERR,
        CMD_ROW_W,
        CMD_ROW_G,
        CMD_WR_W,
        CMD_ACC_G,
        CMD_CLEAR
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t             kind;
        logic [ADDR_W-1:0]     addr;
        logic [DATA_W-1:0]     value;
        logic [DIM_CFG_W-1:0]  len;
    } cmd_t;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic [COL_W-1:0]  col;
        logic              last;
        logic              status;
    } res_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_ROW,
        B_ACC_RD,
        B_ACC_ADD,
        B_ACC_WAIT,
        B_CLEAR
    } back_state_t;

    typedef enum logic [2:0] {
        FA_IDLE,
        FA_SWAP,
        FA_ADD,
        FA_NORM,
        FA_ROUND
    } fa_phase_t;

endpackage

### hdl/egsa_front.sv
`timescale 1ns / 1ps
module egsa_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               accept,
    input  logic [egsa_pkg::ACT_W-1:0]         action,
    input  logic [egsa_pkg::TOKEN_W-1:0]       token_id,
    input  logic [egsa_pkg::COL_W-1:0]         column,
    input  logic [egsa_pkg::DATA_W-1:0]        value,
    input  logic                               cfg_write,
    input  logic [egsa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [egsa_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                               cmd_push,
    output egsa_pkg::cmd_t                     cmd
);

    logic [egsa_pkg::VOCAB_CFG_W-1:0] vocab_reg;
    logic [egsa_pkg::DIM_CFG_W-1:0]   dim_reg;
    logic [egsa_pkg::VOCAB_CMP_W-1:0] eff_vocab;
    logic [egsa_pkg::VOCAB_CMP_W-1:0] vocab_ext;
    logic [egsa_pkg::DIM_CFG_W-1:0]   eff_dim;
    logic                             in_range;
    logic                             col_ok;
    logic                             keep;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vocab_reg <= egsa_pkg::VOCAB_RESET;
            dim_reg   <= egsa_pkg::DIM_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                egsa_pkg::REG_VOCAB: vocab_reg <= cfg_data;
                egsa_pkg::REG_DIM:   dim_reg   <= cfg_data[egsa_pkg::DIM_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        vocab_ext = egsa_pkg::VOCAB_CMP_W'(vocab_reg);
        eff_vocab = (vocab_ext > egsa_pkg::VOCAB_CMP_W'(egsa_pkg::VOCAB))
                    ? egsa_pkg::VOCAB_CMP_W'(egsa_pkg::VOCAB) : vocab_ext;
        if (dim_reg == '0)
            eff_dim = egsa_pkg::DIM_CFG_W'(1);
        else if (dim_reg > egsa_pkg::DIM_CFG_W'(egsa_pkg::ROW_WORDS))
            eff_dim = egsa_pkg::DIM_CFG_W'(egsa_pkg::ROW_WORDS);
        else
            eff_dim = dim_reg;
        in_range = egsa_pkg::VOCAB_CMP_W'(token_id) < eff_vocab;
        col_ok   = egsa_pkg::DIM_CFG_W'(column) < eff_dim;
    end

    // Classify the transaction; dropped items never reach the queue.
    always_comb
    begin
        keep       = 1'b1;
        cmd.kind   = egsa_pkg::CMD_ERR;
        cmd.addr   = {token_id[egsa_pkg::ID_W-1:0], column};
        cmd.value  = value;
        cmd.len    = eff_dim;
        case (action)
            egsa_pkg::ACT_LOAD:
            begin
                if (!in_range)
                    cmd.kind = egsa_pkg::CMD_ERR;
                else
                begin
                    cmd.kind = egsa_pkg::CMD_WR_W;
                    keep     = col_ok;
                end
            end
            egsa_pkg::ACT_ACCUM:
            begin
                if (!in_range)
                    cmd.kind = egsa_pkg::CMD_ERR;
                else
                begin
                    cmd.kind = egsa_pkg::CMD_ACC_G;
                    keep     = col_ok;
                end
            end
            egsa_pkg::ACT_LOOKUP:
                cmd.kind = in_range ? egsa_pkg::CMD_ROW_W : egsa_pkg::CMD_ERR;
            egsa_pkg::ACT_READ_GRAD:
                cmd.kind = in_range ? egsa_pkg::CMD_ROW_G : egsa_pkg::CMD_ERR;
            egsa_pkg::ACT_CLEAR:
                cmd.kind = egsa_pkg::CMD_CLEAR;
            default:
                keep = 1'b0;
        endcase
        cmd_push = accept && keep;
    end

endmodule

### hdl/egsa_cmdq.sv
`timescale 1ns / 1ps
module egsa_cmdq (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  egsa_pkg::cmd_t push_data,
    input  logic           pop,
    output egsa_pkg::cmd_t head,
    output logic           full,
    output logic           empty
);

    localparam int PTR_W = $clog2(egsa_pkg::CMDQ_DEPTH);
    localparam int CNT_W = $clog2(egsa_pkg::CMDQ_DEPTH + 1);

    egsa_pkg::cmd_t   entry_reg [egsa_pkg::CMDQ_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = cnt_reg == CNT_W'(egsa_pkg::CMDQ_DEPTH);
    assign empty   = cnt_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            cnt_reg <= cnt_reg + CNT_W'(do_push) - CNT_W'(do_pop);
        end
    end

endmodule

### hdl/egsa_fpadd.sv
`timescale 1ns / 1ps
module egsa_fpadd (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic        done,
    output logic [31:0] sum
);

    egsa_pkg::fa_phase_t phase_reg, phase_next;

    logic [31:0] a_reg, b_reg;
    logic        sign_reg, zsign_reg, sub_reg, spec_reg;
    logic [31:0] spec_val_reg;
    logic [8:0]  e_reg;
    logic [23:0] mb_reg, ms_reg;
    logic [7:0]  d_reg;
    logic [27:0] s_reg;
    logic [26:0] nm_reg;
    logic        done_reg;
    logic [31:0] sum_reg;

    // Unpack and order by magnitude.
    logic [7:0]  ea, eb, ea_e, eb_e;
    logic [22:0] fa, fb;
    logic        a_nan, b_nan, a_inf, b_inf, a_big;
    logic        c_spec;
    logic [31:0] c_spec_val;

    always_comb
    begin
        ea    = a_reg[30:23];
        eb    = b_reg[30:23];
        fa    = a_reg[22:0];
        fb    = b_reg[22:0];
        ea_e  = (ea == 8'd0) ? 8'd1 : ea;
        eb_e  = (eb == 8'd0) ? 8'd1 : eb;
        a_nan = (&ea) && (|fa);
        b_nan = (&eb) && (|fb);
        a_inf = (&ea) && !(|fa);
        b_inf = (&eb) && !(|fb);
        a_big = a_reg[30:0] >= b_reg[30:0];
        c_spec     = 1'b1;
        c_spec_val = a_reg;
        if (a_nan)
            c_spec_val = a_reg | 32'h0040_0000;
        else if (b_nan)
            c_spec_val = b_reg | 32'h0040_0000;
        else if (a_inf && b_inf && (a_reg[31] != b_reg[31]))
            c_spec_val = 32'hFFC0_0000;
        else if (a_inf)
            c_spec_val = a_reg;
        else if (b_inf)
            c_spec_val = b_reg;
        else
            c_spec = 1'b0;
    end

    // Align the smaller operand with a sticky bit, then add or subtract.
    logic [4:0]  sh_amt;
    logic [53:0] wide;
    logic [26:0] aligned;
    logic [27:0] c_sum;

    always_comb
    begin
        sh_amt  = (d_reg > 8'd27) ? 5'd27 : d_reg[4:0];
        wide    = {ms_reg, 3'b000, 27'd0} >> sh_amt;
        aligned = wide[53:27] | {26'd0, |wide[26:0]};
        if (sub_reg)
            c_sum = {1'b0, mb_reg, 3'b000} - {1'b0, aligned};
        else
            c_sum = {1'b0, mb_reg, 3'b000} + {1'b0, aligned};
    end

    // Normalize; the left shift stops at the subnormal boundary.
    logic [4:0]  lz, nsh;
    logic [8:0]  emax, c_e;
    logic [26:0] c_nm;

    always_comb
    begin
        lz = 5'd27;
        for (int i = 0; i < 27; i++)
        begin
            if (s_reg[i])
                lz = 5'(26 - i);
        end
        emax = e_reg - 9'd1;
        nsh  = (9'(lz) > emax) ? emax[4:0] : lz;
        if (s_reg[27])
        begin
            c_nm = {s_reg[27:2], |s_reg[1:0]};
            c_e  = e_reg + 9'd1;
        end
        else
        begin
            c_nm = s_reg[26:0] << nsh;
            c_e  = e_reg - 9'(nsh);
        end
    end

    // Round to nearest even and pack.
    logic [23:0] rm, mr;
    logic        rg, rs, up;
    logic [24:0] m25;
    logic [8:0]  er;
    logic [31:0] c_res;

    always_comb
    begin
        rm  = nm_reg[26:3];
        rg  = nm_reg[2];
        rs  = |nm_reg[1:0];
        up  = rg && (rs || rm[0]);
        m25 = {1'b0, rm} + 25'(up);
        if (m25[24])
        begin
            mr = m25[24:1];
            er = e_reg + 9'd1;
        end
        else
        begin
            mr = m25[23:0];
            er = e_reg;
        end
        if (spec_reg)
            c_res = spec_val_reg;
        else if (s_reg == '0)
            c_res = {zsign_reg, 31'd0};
        else if (er >= 9'd255)
            c_res = {sign_reg, 8'hFF, 23'd0};
        else
            c_res = {sign_reg, (mr[23] ? er[7:0] : 8'h00), mr[22:0]};
    end

    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            egsa_pkg::FA_IDLE:  if (start) phase_next = egsa_pkg::FA_SWAP;
            egsa_pkg::FA_SWAP:  phase_next = egsa_pkg::FA_ADD;
            egsa_pkg::FA_ADD:   phase_next = egsa_pkg::FA_NORM;
            egsa_pkg::FA_NORM:  phase_next = egsa_pkg::FA_ROUND;
            egsa_pkg::FA_ROUND: phase_next = egsa_pkg::FA_IDLE;
            default:            phase_next = egsa_pkg::FA_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= egsa_pkg::FA_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= phase_reg == egsa_pkg::FA_ROUND;
        end
    end

    always_ff @(posedge clk)
    begin
        case (phase_reg)
            egsa_pkg::FA_IDLE:
            begin
                if (start)
                begin
                    a_reg <= a;
                    b_reg <= b;
                end
            end
            egsa_pkg::FA_SWAP:
            begin
                spec_reg     <= c_spec;
                spec_val_reg <= c_spec_val;
                sign_reg     <= a_big ? a_reg[31] : b_reg[31];
                sub_reg      <= a_reg[31] ^ b_reg[31];
                zsign_reg    <= a_reg[31] & b_reg[31];
                e_reg        <= {1'b0, (a_big ? ea_e : eb_e)};
                mb_reg       <= a_big ? {ea != 8'd0, fa} : {eb != 8'd0, fb};
                ms_reg       <= a_big ? {eb != 8'd0, fb} : {ea != 8'd0, fa};
                d_reg        <= a_big ? (ea_e - eb_e) : (eb_e - ea_e);
            end
            egsa_pkg::FA_ADD:
                s_reg <= c_sum;
            egsa_pkg::FA_NORM:
            begin
                nm_reg <= c_nm;
                e_reg  <= c_e;
            end
            egsa_pkg::FA_ROUND:
                sum_reg <= c_res;
            default: ;
        endcase
    end

    assign done = done_reg;
    assign sum  = sum_reg;

endmodule

### hdl/egsa_back.sv
`timescale 1ns / 1ps
module egsa_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  egsa_pkg::cmd_t                  cmd,
    input  logic                            cmd_empty,
    output logic                            cmd_pop,
    output logic                            init_busy,
    input  logic                            res_pop,
    output logic                            res_empty,
    output egsa_pkg::res_t                  res_head
);

    localparam int ADDR_W = egsa_pkg::ADDR_W;
    localparam int COL_W  = egsa_pkg::COL_W;
    localparam int OQ_PTR_W = $clog2(egsa_pkg::OUTQ_DEPTH);
    localparam int OQ_CNT_W = $clog2(egsa_pkg::OUTQ_DEPTH + 1);

    egsa_pkg::back_state_t state_reg, state_next;

    logic [31:0] w_mem [egsa_pkg::TABLE_WORDS];
    logic [31:0] g_mem [egsa_pkg::TABLE_WORDS];
    logic [31:0] w_rdata_reg, g_rdata_reg;

    logic [ADDR_W-1:0]              addr_reg, clr_idx_reg, clr_idx_next;
    logic [31:0]                    val_reg;
    logic [egsa_pkg::DIM_CFG_W-1:0] len_reg;
    logic                           sel_g_reg;
    logic [COL_W-1:0]               col_reg, col_next;
    logic                           init_reg, init_next;

    logic             rd_pv_reg, rd_last_reg, rd_g_reg;
    logic [COL_W-1:0] rd_col_reg;

    logic              w_we, w_re, g_we, g_re, rd_issue, row_last, err_push, room;
    logic [ADDR_W-1:0] raddr, g_waddr;
    logic [31:0]       g_wdata;
    logic              fa_start, fa_done;
    logic [31:0]       fa_sum;

    egsa_pkg::res_t       oq_reg [egsa_pkg::OUTQ_DEPTH];
    logic [OQ_PTR_W-1:0]  oq_wr_reg, oq_rd_reg;
    logic [OQ_CNT_W-1:0]  oq_cnt_reg;
    logic                 oq_push, oq_pop;
    egsa_pkg::res_t       oq_data;

    egsa_fpadd u_fpadd (
        .clk   (clk),
        .rst_n (rst_n),
        .start (fa_start),
        .a     (g_rdata_reg),
        .b     (val_reg),
        .done  (fa_done),
        .sum   (fa_sum)
    );

    // Leave space for a read already in flight so a row never overruns the queue.
    assign room = (oq_cnt_reg + OQ_CNT_W'(rd_pv_reg)) < OQ_CNT_W'(egsa_pkg::OUTQ_DEPTH);
    assign row_last = (egsa_pkg::DIM_CFG_W'(col_reg) + egsa_pkg::DIM_CFG_W'(1)) == len_reg;

    always_comb
    begin
        state_next   = state_reg;
        cmd_pop      = 1'b0;
        w_we         = 1'b0;
        w_re         = 1'b0;
        g_we         = 1'b0;
        g_re         = 1'b0;
        g_waddr      = addr_reg;
        g_wdata      = fa_sum;
        raddr        = {addr_reg[ADDR_W-1:COL_W], col_reg};
        rd_issue     = 1'b0;
        err_push     = 1'b0;
        fa_start     = 1'b0;
        col_next     = col_reg;
        clr_idx_next = clr_idx_reg;
        init_next    = init_reg;
        case (state_reg)
            egsa_pkg::B_IDLE:
            begin
                if (!cmd_empty && !rd_pv_reg && room)
                begin
                    cmd_pop  = 1'b1;
                    col_next = '0;
                    case (cmd.kind)
                        egsa_pkg::CMD_ERR:   err_push   = 1'b1;
                        egsa_pkg::CMD_ROW_W: state_next = egsa_pkg::B_ROW;
                        egsa_pkg::CMD_ROW_G: state_next = egsa_pkg::B_ROW;
                        egsa_pkg::CMD_WR_W:  w_we       = 1'b1;
                        egsa_pkg::CMD_ACC_G: state_next = egsa_pkg::B_ACC_RD;
                        egsa_pkg::CMD_CLEAR: state_next = egsa_pkg::B_CLEAR;
                        default: ;
                    endcase
                end
            end
            egsa_pkg::B_ROW:
            begin
                if (room)
                begin
                    rd_issue = 1'b1;
                    g_re     = sel_g_reg;
                    w_re     = !sel_g_reg;
                    if (row_last)
                        state_next = egsa_pkg::B_IDLE;
                    else
                        col_next = col_reg + COL_W'(1);
                end
            end
            egsa_pkg::B_ACC_RD:
            begin
                g_re       = 1'b1;
                raddr      = addr_reg;
                state_next = egsa_pkg::B_ACC_ADD;
            end
            egsa_pkg::B_ACC_ADD:
            begin
                fa_start   = 1'b1;
                state_next = egsa_pkg::B_ACC_WAIT;
            end
            egsa_pkg::B_ACC_WAIT:
            begin
                if (fa_done)
                begin
                    g_we       = 1'b1;
                    state_next = egsa_pkg::B_IDLE;
                end
            end
            egsa_pkg::B_CLEAR:
            begin
                g_we         = 1'b1;
                g_waddr      = clr_idx_reg;
                g_wdata      = '0;
                clr_idx_next = clr_idx_reg + ADDR_W'(1);
                if (&clr_idx_reg)
                begin
                    state_next = egsa_pkg::B_IDLE;
                    init_next  = 1'b0;
                end
            end
            default: state_next = egsa_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= egsa_pkg::B_CLEAR;
            init_reg    <= 1'b1;
            clr_idx_reg <= '0;
            col_reg     <= '0;
            rd_pv_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            init_reg    <= init_next;
            clr_idx_reg <= clr_idx_next;
            col_reg     <= col_next;
            rd_pv_reg   <= rd_issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            addr_reg  <= cmd.addr;
            val_reg   <= cmd.value;
            len_reg   <= cmd.len;
            sel_g_reg <= cmd.kind == egsa_pkg::CMD_ROW_G;
        end
        rd_col_reg  <= col_reg;
        rd_last_reg <= row_last;
        rd_g_reg    <= sel_g_reg;
    end

    always_ff @(posedge clk)
    begin
        if (w_we)
            w_mem[cmd.addr] <= cmd.value;
        if (w_re)
            w_rdata_reg <= w_mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (g_we)
            g_mem[g_waddr] <= g_wdata;
        if (g_re)
            g_rdata_reg <= g_mem[raddr];
    end

    // Result queue.
    always_comb
    begin
        oq_push = rd_pv_reg || err_push;
        if (rd_pv_reg)
        begin
            oq_data.data   = rd_g_reg ? g_rdata_reg : w_rdata_reg;
            oq_data.col    = rd_col_reg;
            oq_data.last   = rd_last_reg;
            oq_data.status = 1'b0;
        end
        else
        begin
            oq_data.data   = '0;
            oq_data.col    = '0;
            oq_data.last   = 1'b1;
            oq_data.status = 1'b1;
        end
        oq_pop = res_pop && (oq_cnt_reg != '0);
    end

    always_ff @(posedge clk)
    begin
        if (oq_push)
            oq_reg[oq_wr_reg] <= oq_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_reg  <= '0;
            oq_rd_reg  <= '0;
            oq_cnt_reg <= '0;
        end
        else
        begin
            if (oq_push)
                oq_wr_reg <= oq_wr_reg + OQ_PTR_W'(1);
            if (oq_pop)
                oq_rd_reg <= oq_rd_reg + OQ_PTR_W'(1);
            oq_cnt_reg <= oq_cnt_reg + OQ_CNT_W'(oq_push) - OQ_CNT_W'(oq_pop);
        end
    end

    assign res_empty = oq_cnt_reg == '0;
    assign res_head  = oq_reg[oq_rd_reg];
    assign init_busy = init_reg;

endmodule

### hdl/embedding_gather_scatter_add.sv
// Embedding table engine with a weight table and a gradient table of fp32 words, 1024 rows by
// 16 columns. After reset the gradient table is swept to zero one word per cycle, and full
// stays high meanwhile. A lookup or gradient row read emits dim_in_use results, one per cycle
// from the table's single read port while the result queue has room; a weight load or an
// out-of-range error is handled without leaving the idle state; a gradient accumulate goes
// through the read, the four-step fp32 adder and the write back; a gradient clear sweeps the
// table one word per cycle. A short command queue lets the input side keep accepting
// transactions while the table side works.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module embedding_gather_scatter_add (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic [egsa_pkg::ACT_W-1:0]         action,
    input  logic [egsa_pkg::TOKEN_W-1:0]       token_id,
    input  logic [egsa_pkg::COL_W-1:0]         column,
    input  logic [egsa_pkg::DATA_W-1:0]        value,
    output logic                               empty,
    input  logic                               pop,
    output logic [egsa_pkg::DATA_W-1:0]        data,
    output logic [egsa_pkg::COL_W-1:0]         out_column,
    output logic                               last,
    output logic                               status,
    input  logic                               cfg_write,
    input  logic [egsa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [egsa_pkg::CFG_DATA_W-1:0]    cfg_data
);

    egsa_pkg::cmd_t cmd_in, cmd_head;
    egsa_pkg::res_t res_head;
    logic           accept, cmd_push, cmd_pop, cmdq_full, cmdq_empty, init_busy;

    assign full   = cmdq_full || init_busy;
    assign accept = push && !full;

    egsa_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .action    (action),
        .token_id  (token_id),
        .column    (column),
        .value     (value),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_push  (cmd_push),
        .cmd       (cmd_in)
    );

    egsa_cmdq u_cmdq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data (cmd_in),
        .pop       (cmd_pop),
        .head      (cmd_head),
        .full      (cmdq_full),
        .empty     (cmdq_empty)
    );

    egsa_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_head),
        .cmd_empty (cmdq_empty),
        .cmd_pop   (cmd_pop),
        .init_busy (init_busy),
        .res_pop   (pop),
        .res_empty (empty),
        .res_head  (res_head)
    );

    assign data       = res_head.data;
    assign out_column = res_head.col;
    assign last       = res_head.last;
    assign status     = res_head.status;

    `EGSA_NEVER(a_cmd_overflow, cmd_push && cmdq_full, "command pushed into a full queue")
    `EGSA_NEVER(a_cmd_underflow, cmd_pop && cmdq_empty, "command taken from an empty queue")
    `EGSA_IMPLIES(a_init_quiet, init_busy, !cmd_pop, "command executed during initial clear")

endmodule

### dv/embedding_gather_scatter_add_tb.sv
`timescale 1ns / 1ps
module embedding_gather_scatter_add_tb;

    localparam int HANG_LIMIT = 400000;

    class embed_table_model;
        logic [egsa_pkg::DATA_W-1:0] weights [egsa_pkg::TABLE_WORDS];
        logic [egsa_pkg::DATA_W-1:0] grads [egsa_pkg::TABLE_WORDS];
        egsa_pkg::res_t              expected_words [$];
        int unsigned                 vocab_reg;
        int unsigned                 dim_reg;
        int                          errors;

        function new();
            foreach (grads[i]) grads[i] = '0;
            foreach (weights[i]) weights[i] = '0;
            vocab_reg = egsa_pkg::VOCAB_RESET;
            dim_reg = egsa_pkg::DIM_RESET;
            errors = 0;
        endfunction

        function int unsigned eff_vocab();
            return (vocab_reg > egsa_pkg::VOCAB) ? egsa_pkg::VOCAB : vocab_reg;
        endfunction

        function int unsigned eff_dim();
            if (dim_reg == 0)
                return 1;
            return (dim_reg > egsa_pkg::ROW_WORDS) ? egsa_pkg::ROW_WORDS : dim_reg;
        endfunction

        // IEEE single-precision add, round to nearest even. NaNs propagate quieted,
        // the first operand winning; inf minus inf gives the default negative NaN.
        function logic [31:0] fp32_add(logic [31:0] a, logic [31:0] b);
            logic        sa, sb, st, rs, sticky;
            logic [7:0]  ea, eb;
            logic [27:0] ma, mb, s, mt;
            logic [24:0] r;
            logic [2:0]  g;
            int          xa, xb, xt, d, ex;
            sa = a[31];
            sb = b[31];
            ea = a[30:23];
            eb = b[30:23];
            if (ea == 8'hFF && a[22:0] != 0)
                return a | 32'h0040_0000;
            if (eb == 8'hFF && b[22:0] != 0)
                return b | 32'h0040_0000;
            if (ea == 8'hFF)
                return (eb == 8'hFF && sa != sb) ? 32'hFFC0_0000 : a;
            if (eb == 8'hFF)
                return b;
            ma = {1'b0, ea != 0, a[22:0], 3'b0};
            mb = {1'b0, eb != 0, b[22:0], 3'b0};
            xa = (ea == 0) ? 1 : ea;
            xb = (eb == 0) ? 1 : eb;
            if (xb > xa || (xb == xa && mb > ma))
            begin
                mt = ma; ma = mb; mb = mt;
                xt = xa; xa = xb; xb = xt;
                st = sa; sa = sb; sb = st;
            end
            d = xa - xb;
            if (d >= 27)
            begin
                sticky = (mb != 0);
                mb = {27'b0, sticky};
            end
            else if (d > 0)
            begin
                sticky = ((mb & ((28'd1 << d) - 1)) != 0);
                mb = (mb >> d) | sticky;
            end
            s = (sa == sb) ? ma + mb : ma - mb;
            if (s == 0)
                return {sa & sb, 31'b0};
            rs = sa;
            ex = xa;
            if (s[27])
            begin
                s = (s >> 1) | s[0];
                ex++;
            end
            else
            begin
                while (!s[26] && ex > 1)
                begin
                    s = s << 1;
                    ex--;
                end
            end
            g = s[2:0];
            r = {1'b0, s[26:3]};
            if (g > 3'd4 || (g == 3'd4 && r[0]))
                r = r + 1;
            if (r[24])
            begin
                r = r >> 1;
                ex++;
            end
            if (ex >= 255)
                return {rs, 8'hFF, 23'b0};
            return {rs, r[23] ? ex[7:0] : 8'd0, r[22:0]};
        endfunction

        function void emit_row(bit from_grads, int unsigned id);
            int unsigned d;
            egsa_pkg::res_t w;
            d = eff_dim();
            for (int unsigned c = 0; c < d; c++)
            begin
                w.data = from_grads ? grads[id * egsa_pkg::ROW_WORDS + c]
                                    : weights[id * egsa_pkg::ROW_WORDS + c];
                w.col = c[egsa_pkg::COL_W-1:0];
                w.last = (c + 1 == d);
                w.status = 1'b0;
                expected_words = {expected_words, w};
            end
        endfunction

        function void note_command(logic [egsa_pkg::ACT_W-1:0] act,
                                   logic [egsa_pkg::TOKEN_W-1:0] id,
                                   logic [egsa_pkg::COL_W-1:0] col,
                                   logic [egsa_pkg::DATA_W-1:0] val);
            int unsigned idx;
            egsa_pkg::res_t w;
            if (act == egsa_pkg::ACT_CLEAR)
            begin
                foreach (grads[i]) grads[i] = '0;
                return;
            end
            if (act > egsa_pkg::ACT_CLEAR)
                return;
            if (id >= eff_vocab())
            begin
                w = '{data: '0, col: '0, last: 1'b1, status: 1'b1};
                expected_words = {expected_words, w};
                return;
            end
            if (act == egsa_pkg::ACT_LOOKUP)
                emit_row(1'b0, id);
            else if (act == egsa_pkg::ACT_READ_GRAD)
                emit_row(1'b1, id);
            else if (col < eff_dim())
            begin
                idx = id * egsa_pkg::ROW_WORDS + col;
                if (act == egsa_pkg::ACT_LOAD)
                    weights[idx] = val;
                else
                    grads[idx] = fp32_add(grads[idx], val);
            end
        endfunction

        function void check_word(logic [egsa_pkg::DATA_W-1:0] d,
                                 logic [egsa_pkg::COL_W-1:0] c,
                                 logic l, logic s);
            egsa_pkg::res_t w;
            if (expected_words.size() == 0)
            begin
                $error("unexpected result transaction: data %h column %0d", d, c);
                errors++;
                return;
            end
            w = expected_words.pop_front();
            if (d !== w.data)
            begin
                $error("data: expected %h, actual %h", w.data, d);
                errors++;
            end
            if (c !== w.col)
            begin
                $error("out_column: expected %0d, actual %0d", w.col, c);
                errors++;
            end
            if (l !== w.last)
            begin
                $error("last: expected %0d, actual %0d", w.last, l);
                errors++;
            end
            if (s !== w.status)
            begin
                $error("status: expected %0d, actual %0d", w.status, s);
                errors++;
            end
        endfunction
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            push;
    logic                            full;
    logic [egsa_pkg::ACT_W-1:0]      action;
    logic [egsa_pkg::TOKEN_W-1:0]    token_id;
    logic [egsa_pkg::COL_W-1:0]      column;
    logic [egsa_pkg::DATA_W-1:0]     value;
    logic                            empty;
    logic                            pop;
    logic [egsa_pkg::DATA_W-1:0]     data;
    logic [egsa_pkg::COL_W-1:0]      out_column;
    logic                            last;
    logic                            status;
    logic                            cfg_write;
    logic [egsa_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [egsa_pkg::CFG_DATA_W-1:0] cfg_data;

    embed_table_model model;
    bit   weight_written [egsa_pkg::TABLE_WORDS];
    int   send_idle_pct;
    int   recv_idle_pct;
    bit   hold_request;
    int   stall_cycles = 0;

    embedding_gather_scatter_add DUT (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .action(action),
        .token_id(token_id),
        .column(column),
        .value(value),
        .empty(empty),
        .pop(pop),
        .data(data),
        .out_column(out_column),
        .last(last),
        .status(status),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Hang detection: cycles in which neither side completes a transaction.
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= HANG_LIMIT)
        begin
            $display("embedding_gather_scatter_add test failed");
            $finish;
        end
    end

    // Result side: random pop, with one long hold-off on request.
    initial
    begin
        pop = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                pop = 1'b0;
                repeat (400) @(negedge clk);
                hold_request = 1'b0;
            end
            pop = ($urandom_range(99) >= recv_idle_pct);
            @(posedge clk);
            if (pop && !empty)
                model.check_word(data, out_column, last, status);
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance with push
    // still high, so back-to-back transactions never toggle it.
    task automatic send_cmd(int unsigned act, int unsigned id, int unsigned col,
                            logic [31:0] val);
        logic [egsa_pkg::ACT_W-1:0]   a;
        logic [egsa_pkg::TOKEN_W-1:0] t;
        logic [egsa_pkg::COL_W-1:0]   c;
        a = act[egsa_pkg::ACT_W-1:0];
        t = id[egsa_pkg::TOKEN_W-1:0];
        c = col[egsa_pkg::COL_W-1:0];
        if ($urandom_range(99) < send_idle_pct)
        begin
            push = 1'b0;
            repeat ($urandom_range(3, 1)) @(negedge clk);
        end
        push = 1'b1;
        action = a;
        token_id = t;
        column = c;
        value = val;
        do
            @(posedge clk);
        while (full);
        model.note_command(a, t, c, val);
        if (a == egsa_pkg::ACT_LOAD && t < model.eff_vocab() && c < model.eff_dim())
            weight_written[t * egsa_pkg::ROW_WORDS + c] = 1'b1;
        @(negedge clk);
    endtask

    task automatic load_row(int unsigned id);
        for (int c = 0; c < egsa_pkg::ROW_WORDS; c++)
            send_cmd(egsa_pkg::ACT_LOAD, id, c, $urandom);
    endtask

    function automatic bit row_ready(int unsigned id);
        for (int unsigned c = 0; c < model.eff_dim(); c++)
            if (!weight_written[id * egsa_pkg::ROW_WORDS + c])
                return 1'b0;
        return 1'b1;
    endfunction

    // Waits until every expected result has come, then lets the block settle.
    task automatic drain();
        push = 1'b0;
        while (model.expected_words.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic write_cfg(logic [egsa_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data = val[egsa_pkg::CFG_DATA_W-1:0];
        @(negedge clk);
        cfg_write = 1'b0;
        if (idx == egsa_pkg::REG_VOCAB)
            model.vocab_reg = val & 32'h7FF;
        else
            model.dim_reg = val & 32'h1F;
    endtask

    function automatic int unsigned pool_id();
        int unsigned r;
        r = $urandom_range(9);
        return (r >= 8) ? model.eff_vocab() - 1 : r % model.eff_vocab();
    endfunction

    function automatic logic [31:0] grad_value();
        if ($urandom_range(9) == 0)
            return $urandom;
        return {1'($urandom_range(1)), 8'($urandom_range(135, 118)), 23'($urandom)};
    endfunction

    task automatic random_phase(int count);
        int          done;
        int unsigned id;
        int unsigned pick;
        done = 0;
        while (done < count)
        begin
            pick = $urandom_range(99);
            id = pool_id();
            if (pick < 30)
            begin
                if (!row_ready(id))
                    load_row(id);
                send_cmd(egsa_pkg::ACT_LOOKUP, id, $urandom, $urandom);
            end
            else if (pick < 55)
                send_cmd(egsa_pkg::ACT_ACCUM, id, $urandom, grad_value());
            else if (pick < 65)
                send_cmd(egsa_pkg::ACT_READ_GRAD, id, $urandom, $urandom);
            else if (pick < 75)
                send_cmd(egsa_pkg::ACT_LOAD, id, $urandom, $urandom);
            else if (pick < 85)
                send_cmd($urandom_range(3), $urandom_range(65535, model.eff_vocab()),
                         $urandom, $urandom);
            else if (pick < 95)
                send_cmd($urandom_range(1) ? egsa_pkg::ACT_ACCUM : egsa_pkg::ACT_LOAD,
                         $urandom, $urandom, grad_value());
            else if (pick < 99)
            begin
                send_cmd($urandom_range(7, 5), $urandom, $urandom, $urandom);
                done--;
            end
            else
                send_cmd(egsa_pkg::ACT_CLEAR, $urandom, $urandom, $urandom);
            done++;
        end
        // A result-bearing transaction last, so the drain covers all earlier work.
        send_cmd(egsa_pkg::ACT_READ_GRAD, 0, 0, 0);
        drain();
    endtask

    initial
    begin
        model = new();
        foreach (weight_written[i]) weight_written[i] = 1'b0;
        rst_n = 1'b0;
        push = 1'b0;
        action = egsa_pkg::ACT_LOAD;
        token_id = '0;
        column = '0;
        value = '0;
        cfg_write = 1'b0;
        cfg_index = egsa_pkg::REG_VOCAB;
        cfg_data = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: table extremes, every action, range errors and fp32 corner cases.
        send_cmd(egsa_pkg::ACT_LOAD, 0, 0, 32'hFFFF_FFFF);
        send_cmd(egsa_pkg::ACT_LOAD, 0, 15, 32'h0000_0000);
        load_row(0);
        load_row(egsa_pkg::VOCAB - 1);
        send_cmd(egsa_pkg::ACT_LOOKUP, 0, 0, 0);
        send_cmd(egsa_pkg::ACT_LOOKUP, egsa_pkg::VOCAB - 1, 15, 0);
        send_cmd(egsa_pkg::ACT_LOOKUP, egsa_pkg::VOCAB, 0, 0);
        send_cmd(egsa_pkg::ACT_LOOKUP, 16'hFFFF, 0, 0);
        send_cmd(egsa_pkg::ACT_ACCUM, 0, 0, 32'h3F80_0000);
        send_cmd(egsa_pkg::ACT_ACCUM, 0, 0, 32'h3F80_0000);
        send_cmd(egsa_pkg::ACT_ACCUM, 0, 15, 32'h7F7F_FFFF);
        send_cmd(egsa_pkg::ACT_ACCUM, 0, 15, 32'h7F7F_FFFF);
        send_cmd(egsa_pkg::ACT_ACCUM, 0, 1, 32'h0000_0001);
        send_cmd(egsa_pkg::ACT_ACCUM, 0, 1, 32'h8000_0003);
        send_cmd(egsa_pkg::ACT_ACCUM, 0, 2, 32'h7FC0_0001);
        send_cmd(egsa_pkg::ACT_ACCUM, 2000, 3, 32'h3F80_0000);
        send_cmd(egsa_pkg::ACT_READ_GRAD, 0, 0, 0);
        send_cmd(egsa_pkg::ACT_READ_GRAD, egsa_pkg::VOCAB - 1, 0, 0);
        send_cmd(3'd5, 0, 0, 0);
        send_cmd(3'd7, 16'hFFFF, 4'hF, 32'hFFFF_FFFF);
        send_cmd(egsa_pkg::ACT_CLEAR, 0, 0, 0);
        send_cmd(egsa_pkg::ACT_READ_GRAD, 0, 0, 0);
        send_cmd(egsa_pkg::ACT_LOAD, 16'hFFFF, 4'hF, 32'hFFFF_FFFF);
        drain();

        write_cfg(egsa_pkg::REG_VOCAB, 2047);
        write_cfg(egsa_pkg::REG_DIM, 31);
        send_idle_pct = 8;
        recv_idle_pct = 78;
        random_phase(60);

        write_cfg(egsa_pkg::REG_VOCAB, 1);
        write_cfg(egsa_pkg::REG_DIM, 0);
        send_idle_pct = 78;
        recv_idle_pct = 8;
        random_phase(40);

        write_cfg(egsa_pkg::REG_VOCAB, 700);
        write_cfg(egsa_pkg::REG_DIM, 5);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request = 1'b1;
        random_phase(80);

        push = 1'b0;
        drain();
        if (model.expected_words.size() != 0)
        begin
            $error("%0d expected results never arrived", model.expected_words.size());
            model.errors++;
        end
        if (model.errors == 0)
            $display("embedding_gather_scatter_add test passed");
        else
            $display("embedding_gather_scatter_add test failed");
        $finish;
    end
endmodule
